// File: hdl/spp_pkg.sv
package spp_pkg;

    // Field and register widths
    localparam int COORD_BITS_DEF = 24;
    localparam int SCALE_BITS     = 24;
    localparam int FADE_BITS      = 24;
    localparam int SCREEN_BITS    = 10;
    localparam int WORD_BITS      = 32;
    localparam int CFG_ADDR_BITS  = 3;

    // Depth in Q.8 is below 2^17 inside the drawn range
    localparam int DEPTH_BITS = 17;
    // Quotient bits kept by the divider; anything larger is off screen
    localparam int QBITS      = 11;

    localparam int DEPTH_NEAR = 2048;
    localparam int DEPTH_FAR  = 76800;
    localparam int SHADE_MAX  = 255;
    localparam int FADE_SHIFT = 24;
    localparam int PROD_SHIFT = 8;
    localparam int RECT_X_POS = 14;
    localparam int RECT_Y_POS = 2;

    localparam logic [WORD_BITS-1:0] CMD_SETUP = 32'h0600_0000;
    localparam logic [WORD_BITS-1:0] CMD_COLOR = 32'hFA00_0000;
    localparam logic [WORD_BITS-1:0] CMD_RECT  = 32'hF600_0000;
    localparam logic [7:0]           ALPHA_OPAQUE = 8'hFF;

    localparam logic [SCREEN_BITS-1:0] SCREEN_W_RST = 10'd320;
    localparam logic [SCREEN_BITS-1:0] SCREEN_H_RST = 10'd240;

    typedef enum logic [CFG_ADDR_BITS-1:0] {
        REG_PROJ_SCALE = 3'd0,
        REG_FADE_SCALE = 3'd1,
        REG_SCREEN_W   = 3'd2,
        REG_SCREEN_H   = 3'd3,
        REG_SETUP_ADDR = 3'd4
    } reg_addr_t;

    typedef enum logic [1:0] {
        KIND_DROP  = 2'd0,
        KIND_SETUP = 2'd1,
        KIND_STAR  = 2'd2
    } item_kind_t;

    // Per-item control that rides alongside the arithmetic
    typedef struct packed {
        item_kind_t kind;
        logic       x_neg;
        logic       y_neg;
        logic       x_ovf;
        logic       y_ovf;
        logic [7:0] shade;
    } side_t;

endpackage

// File: hdl/spp_if.sv
interface spp_in_if #(parameter int COORD_BITS = spp_pkg::COORD_BITS_DEF);
    logic                         valid;
    logic                         ready;
    logic                         mode;
    logic signed [COORD_BITS-1:0] star_x;
    logic signed [COORD_BITS-1:0] star_y;
    logic signed [COORD_BITS-1:0] star_z;

    modport source (output valid, mode, star_x, star_y, star_z, input ready);
    modport sink   (input valid, mode, star_x, star_y, star_z, output ready);
endinterface

interface spp_out_if;
    logic                             valid;
    logic                             ready;
    logic [spp_pkg::WORD_BITS-1:0]    word_high;
    logic [spp_pkg::WORD_BITS-1:0]    word_low;
    logic                             last_of_run;

    modport source (output valid, word_high, word_low, last_of_run, input ready);
    modport sink   (input valid, word_high, word_low, last_of_run, output ready);
endinterface

interface spp_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [spp_pkg::CFG_ADDR_BITS-1:0] addr;
    logic [spp_pkg::WORD_BITS-1:0]     data;

    modport source (output valid, addr, data, input ready);
    modport sink   (input valid, addr, data, output ready);
endinterface

// File: hdl/spp_div_pipe.sv
// Two-lane restoring divider, one quotient bit per stage.
// Each lane enters with a partial remainder below the divisor and the
// low numerator bits still to be brought down.
module spp_div_pipe
(
    input  logic                                   clk,
    input  logic [spp_pkg::QBITS-1:0]              ld,
    input  logic [spp_pkg::DEPTH_BITS-1:0]         z_in,
    input  logic [spp_pkg::DEPTH_BITS-1:0]         rx_in,
    input  logic [spp_pkg::DEPTH_BITS-1:0]         ry_in,
    input  logic [spp_pkg::QBITS-1:0]              lx_in,
    input  logic [spp_pkg::QBITS-1:0]              ly_in,
    output logic [spp_pkg::QBITS-1:0]              qx,
    output logic [spp_pkg::QBITS-1:0]              qy
);

    localparam int DB = spp_pkg::DEPTH_BITS;
    localparam int QB = spp_pkg::QBITS;

    // Bring down one bit, subtract the divisor where it fits
    function automatic logic [DB:0] div_step(input logic [DB-1:0] r,
                                             input logic b,
                                             input logic [DB-1:0] z);
        logic [DB:0] r2;
        logic [DB:0] res;
        r2 = {r, b};
        if (r2 >= {1'b0, z})
        begin
            res = {1'b1, DB'(r2 - {1'b0, z})};
        end
        else
        begin
            res = {1'b0, r2[DB-1:0]};
        end
        return res;
    endfunction

    // The last stage keeps only the quotients
    logic [DB-1:0] z_reg  [QB-1];
    logic [DB-1:0] rx_reg [QB-1];
    logic [DB-1:0] ry_reg [QB-1];
    logic [QB-1:0] lx_reg [QB-1];
    logic [QB-1:0] ly_reg [QB-1];
    logic [QB-1:0] qx_reg [QB];
    logic [QB-1:0] qy_reg [QB];

    for (genvar k = 0; k < QB; k++)
    begin : g_step
        logic [DB-1:0] z_p;
        logic [DB-1:0] rx_p;
        logic [DB-1:0] ry_p;
        logic [QB-1:0] lx_p;
        logic [QB-1:0] ly_p;
        logic [QB-1:0] qx_p;
        logic [QB-1:0] qy_p;
        logic [DB:0]   sx_next;
        logic [DB:0]   sy_next;

        if (k == 0)
        begin : g_first
            assign z_p  = z_in;
            assign rx_p = rx_in;
            assign ry_p = ry_in;
            assign lx_p = lx_in;
            assign ly_p = ly_in;
            assign qx_p = '0;
            assign qy_p = '0;
        end
        else
        begin : g_next
            assign z_p  = z_reg[k-1];
            assign rx_p = rx_reg[k-1];
            assign ry_p = ry_reg[k-1];
            assign lx_p = lx_reg[k-1];
            assign ly_p = ly_reg[k-1];
            assign qx_p = qx_reg[k-1];
            assign qy_p = qy_reg[k-1];
        end

        assign sx_next = div_step(rx_p, lx_p[QB-1], z_p);
        assign sy_next = div_step(ry_p, ly_p[QB-1], z_p);

        // Shift a quotient bit in
        always_ff @(posedge clk)
        begin
            if (ld[k])
            begin
                qx_reg[k] <= {qx_p[QB-2:0], sx_next[DB]};
                qy_reg[k] <= {qy_p[QB-2:0], sy_next[DB]};
            end
        end

        // Carry remainder, divisor and remaining numerator bits on
        if (k < QB - 1)
        begin : g_carry
            always_ff @(posedge clk)
            begin
                if (ld[k])
                begin
                    z_reg[k]  <= z_p;
                    rx_reg[k] <= sx_next[DB-1:0];
                    ry_reg[k] <= sy_next[DB-1:0];
                    lx_reg[k] <= {lx_p[QB-2:0], 1'b0};
                    ly_reg[k] <= {ly_p[QB-2:0], 1'b0};
                end
            end
        end
    end

    assign qx = qx_reg[QB-1];
    assign qy = qy_reg[QB-1];

endmodule

// File: hdl/star_point_projector.sv
// Star point projector.
// Input channel "star" carries one item per beat: mode 0 is a frame start,
// mode 1 a star at (star_x, star_y, star_z) in signed Q.8. Output channel
// "cmd" carries one display command pair per beat with last_of_run set on
// the final beat of an item. A frame start gives the setup pair, a visible
// star gives a colour pair and then a rectangle pair, a culled star nothing.
// Channel "cfg" writes the five registers by index and is always ready. The
// user must use it only while the block is idle; this is not enforced.
// The datapath is a 14-stage pipeline (input, multiply, divide setup, eleven
// divider steps of one quotient bit each) followed by the output register,
// so one item enters per cycle while cmd does not stall. A star that yields
// two beats holds the output register until both beats have gone out, so
// sustained input is one item per output beat pair. When cmd stalls, items
// close up into empty stages and input ready falls only once every stage is
// full. Reset empties the pipeline and loads the register reset values; no
// item is lost or repeated across a stall.
module star_point_projector #(
    parameter int COORD_BITS = spp_pkg::COORD_BITS_DEF
)
(
    input  logic           clk,
    input  logic           rst_n,
    spp_in_if.sink         star,
    spp_out_if.source      cmd,
    spp_cfg_if.sink        cfg
);

    localparam int CB = COORD_BITS;
    localparam int PW = CB + spp_pkg::SCALE_BITS;
    localparam int NW = PW - spp_pkg::PROD_SHIFT;
    localparam int DB = spp_pkg::DEPTH_BITS;
    localparam int QB = spp_pkg::QBITS;
    localparam int FW = DB + spp_pkg::FADE_BITS;
    localparam int NS = 3 + QB;
    localparam int ZW = (CB > 18) ? CB + 1 : 19;
    localparam int SW = QB + 2;
    localparam int HB = spp_pkg::SCREEN_BITS;
    localparam int WB = spp_pkg::WORD_BITS;

    // ---------------- configuration registers ----------------
    logic [spp_pkg::SCALE_BITS-1:0] scale_reg;
    logic [spp_pkg::FADE_BITS-1:0]  fade_reg;
    logic [HB-1:0]                  width_reg;
    logic [HB-1:0]                  height_reg;
    logic [WB-1:0]                  setup_reg;

    assign cfg.ready = 1'b1;

    // Take a register write; ignore unknown indexes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg  <= '0;
            fade_reg   <= '0;
            width_reg  <= spp_pkg::SCREEN_W_RST;
            height_reg <= spp_pkg::SCREEN_H_RST;
            setup_reg  <= '0;
        end
        else if (cfg.valid)
        begin
            case (cfg.addr)
                spp_pkg::REG_PROJ_SCALE: scale_reg  <= cfg.data[spp_pkg::SCALE_BITS-1:0];
                spp_pkg::REG_FADE_SCALE: fade_reg   <= cfg.data[spp_pkg::FADE_BITS-1:0];
                spp_pkg::REG_SCREEN_W:   width_reg  <= cfg.data[HB-1:0];
                spp_pkg::REG_SCREEN_H:   height_reg <= cfg.data[HB-1:0];
                spp_pkg::REG_SETUP_ADDR: setup_reg  <= cfg.data;
                default: ;
            endcase
        end
    end

    // ---------------- pipeline control ----------------
    logic [NS-1:0]   v_reg;
    logic [NS:0]     ld;
    logic            drain;
    spp_pkg::side_t  side_reg [NS];
    spp_pkg::side_t  side_a_next;
    spp_pkg::side_t  side_c_next;

    // A stage loads when it is empty or its contents move on
    assign ld[NS] = drain;
    for (genvar k = 0; k < NS; k++)
    begin : g_ld
        assign ld[k] = !v_reg[k] || ld[k+1];
    end
    assign star.ready = ld[0];

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (ld[0])
            begin
                v_reg[0] <= star.valid;
            end
            for (int k = 1; k < NS; k++)
            begin
                if (ld[k])
                begin
                    v_reg[k] <= v_reg[k-1];
                end
            end
        end
    end

    // ---------------- stage A: decode and magnitudes ----------------
    logic signed [ZW-1:0] z_ext;
    logic                 in_range;
    logic [CB-1:0]        xm_next;
    logic [CB-1:0]        ym_next;
    logic [CB-1:0]        a_xm_reg;
    logic [CB-1:0]        a_ym_reg;
    logic [DB-1:0]        a_z_reg;
    logic [DB-1:0]        a_zd_reg;

    assign z_ext    = ZW'(star.star_z);
    assign in_range = (z_ext >= $signed(ZW'(spp_pkg::DEPTH_NEAR)))
                   && (z_ext <  $signed(ZW'(spp_pkg::DEPTH_FAR)));
    assign xm_next  = star.star_x[CB-1] ? CB'(~star.star_x + 1'b1) : star.star_x;
    assign ym_next  = star.star_y[CB-1] ? CB'(~star.star_y + 1'b1) : star.star_y;

    always_comb
    begin
        side_a_next       = '0;
        side_a_next.x_neg = star.star_x[CB-1];
        side_a_next.y_neg = star.star_y[CB-1];
        if (!star.mode)
        begin
            side_a_next.kind = spp_pkg::KIND_SETUP;
        end
        else if (in_range)
        begin
            side_a_next.kind = spp_pkg::KIND_STAR;
        end
        else
        begin
            side_a_next.kind = spp_pkg::KIND_DROP;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld[0])
        begin
            side_reg[0] <= side_a_next;
            a_xm_reg    <= xm_next;
            a_ym_reg    <= ym_next;
            a_z_reg     <= z_ext[DB-1:0];
            a_zd_reg    <= DB'(z_ext[DB-1:0] - DB'(spp_pkg::DEPTH_NEAR));
        end
    end

    // ---------------- stage B: products ----------------
    logic [PW-1:0] b_px_reg;
    logic [PW-1:0] b_py_reg;
    logic [FW-1:0] b_pf_reg;
    logic [DB-1:0] b_z_reg;

    always_ff @(posedge clk)
    begin
        if (ld[1])
        begin
            side_reg[1] <= side_reg[0];
            b_px_reg    <= PW'(a_xm_reg) * PW'(scale_reg);
            b_py_reg    <= PW'(a_ym_reg) * PW'(scale_reg);
            b_pf_reg    <= FW'(a_zd_reg) * FW'(fade_reg);
            b_z_reg     <= a_z_reg;
        end
    end

    // ---------------- stage C: range check, divider setup, shade ----------------
    logic [NW-1:0] nx;
    logic [NW-1:0] ny;
    logic [DB-1:0] fall;
    logic [DB-1:0] c_z_reg;
    logic [DB-1:0] c_rx_reg;
    logic [DB-1:0] c_ry_reg;
    logic [QB-1:0] c_lx_reg;
    logic [QB-1:0] c_ly_reg;

    assign nx   = b_px_reg[PW-1:spp_pkg::PROD_SHIFT];
    assign ny   = b_py_reg[PW-1:spp_pkg::PROD_SHIFT];
    assign fall = b_pf_reg[FW-1:spp_pkg::FADE_SHIFT];

    // Quotients of 2^QBITS or more are flagged and never reach the screen
    always_comb
    begin
        side_c_next       = side_reg[1];
        side_c_next.x_ovf = nx[NW-1:QB] >= (NW-QB)'(b_z_reg);
        side_c_next.y_ovf = ny[NW-1:QB] >= (NW-QB)'(b_z_reg);
        if (fall > DB'(spp_pkg::SHADE_MAX))
        begin
            side_c_next.shade = '0;
        end
        else
        begin
            side_c_next.shade = 8'(DB'(spp_pkg::SHADE_MAX) - fall);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld[2])
        begin
            side_reg[2] <= side_c_next;
            c_z_reg     <= b_z_reg;
            c_rx_reg    <= nx[QB+DB-1:QB];
            c_ry_reg    <= ny[QB+DB-1:QB];
            c_lx_reg    <= nx[QB-1:0];
            c_ly_reg    <= ny[QB-1:0];
        end
    end

    // ---------------- divider stages ----------------
    logic [QB-1:0] qx;
    logic [QB-1:0] qy;

    spp_div_pipe u_div
    (
        .clk   (clk),
        .ld    (ld[NS-1:3]),
        .z_in  (c_z_reg),
        .rx_in (c_rx_reg),
        .ry_in (c_ry_reg),
        .lx_in (c_lx_reg),
        .ly_in (c_ly_reg),
        .qx    (qx),
        .qy    (qy)
    );

    // Carry control alongside the divider
    for (genvar k = 3; k < NS; k++)
    begin : g_side
        always_ff @(posedge clk)
        begin
            if (ld[k])
            begin
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    // ---------------- screen position, cull and command build ----------------
    spp_pkg::side_t      side_f;
    logic signed [SW-1:0] qxs;
    logic signed [SW-1:0] qys;
    logic signed [SW-1:0] sx;
    logic signed [SW-1:0] sy;
    logic signed [SW-1:0] w_s;
    logic signed [SW-1:0] h_s;
    logic                 visible;
    logic [HB-1:0]        ux;
    logic [HB-1:0]        uy;
    logic [HB-1:0]        ux1;
    logic [HB-1:0]        uy1;
    logic [7:0]           shade;
    logic [1:0]           cnt_next;
    logic [WB-1:0]        hi0_next;
    logic [WB-1:0]        lo0_next;

    assign side_f = side_reg[NS-1];
    assign shade  = side_f.shade;
    assign qxs    = side_f.x_neg ? -$signed({2'b00, qx}) : $signed({2'b00, qx});
    assign qys    = side_f.y_neg ? -$signed({2'b00, qy}) : $signed({2'b00, qy});
    assign w_s    = $signed(SW'(width_reg));
    assign h_s    = $signed(SW'(height_reg));
    assign sx     = qxs + $signed(SW'(width_reg[HB-1:1]));
    assign sy     = $signed(SW'(height_reg[HB-1:1])) - qys;
    assign visible = !side_f.x_ovf && !side_f.y_ovf
                  && !sx[SW-1] && !sy[SW-1] && (sx < w_s) && (sy < h_s);
    assign ux  = sx[HB-1:0];
    assign uy  = sy[HB-1:0];
    assign ux1 = ux + 1'b1;
    assign uy1 = uy + 1'b1;

    always_comb
    begin
        cnt_next = 2'd0;
        hi0_next = spp_pkg::CMD_COLOR;
        lo0_next = {shade, shade, shade, spp_pkg::ALPHA_OPAQUE};
        case (side_f.kind)
            spp_pkg::KIND_SETUP:
            begin
                cnt_next = 2'd1;
                hi0_next = spp_pkg::CMD_SETUP;
                lo0_next = setup_reg;
            end
            spp_pkg::KIND_STAR:
            begin
                cnt_next = visible ? 2'd2 : 2'd0;
            end
            default: ;
        endcase
    end

    // ---------------- output register ----------------
    logic          ov_reg;
    logic          two_reg;
    logic          sel_reg;
    logic [WB-1:0] hi0_reg;
    logic [WB-1:0] lo0_reg;
    logic [WB-1:0] hi1_reg;
    logic [WB-1:0] lo1_reg;

    // Free once the final beat of the held item goes out
    assign drain = !ov_reg || (cmd.ready && (!two_reg || sel_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ov_reg  <= 1'b0;
            two_reg <= 1'b0;
            sel_reg <= 1'b0;
        end
        else if (drain)
        begin
            ov_reg  <= v_reg[NS-1] && (cnt_next != 2'd0);
            two_reg <= (cnt_next == 2'd2);
            sel_reg <= 1'b0;
        end
        else if (cmd.ready)
        begin
            sel_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (drain)
        begin
            hi0_reg <= hi0_next;
            lo0_reg <= lo0_next;
            hi1_reg <= spp_pkg::CMD_RECT
                     | (WB'(ux1) << spp_pkg::RECT_X_POS)
                     | (WB'(uy1) << spp_pkg::RECT_Y_POS);
            lo1_reg <= (WB'(ux) << spp_pkg::RECT_X_POS)
                     | (WB'(uy) << spp_pkg::RECT_Y_POS);
        end
    end

    assign cmd.valid       = ov_reg;
    assign cmd.word_high   = sel_reg ? hi1_reg : hi0_reg;
    assign cmd.word_low    = sel_reg ? lo1_reg : lo0_reg;
    assign cmd.last_of_run = !two_reg || sel_reg;

    // ---------------- assertions ----------------
    a_sel_only_pair: assert property (@(posedge clk) disable iff (!rst_n)
        sel_reg |-> (two_reg && ov_reg))
        else $error("second beat selected without a held pair");

    a_first_is_colour: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.valid && !cmd.last_of_run) |-> (cmd.word_high == spp_pkg::CMD_COLOR))
        else $error("non-final beat is not a colour command");

    a_rect_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.valid && cmd.ready && !cmd.last_of_run)
        |=> (cmd.valid && cmd.last_of_run
             && (cmd.word_high[WB-1:WB-8] == spp_pkg::CMD_RECT[WB-1:WB-8])))
        else $error("colour beat not followed by rectangle beat");

    a_empty_accepts: assert property (@(posedge clk) disable iff (!rst_n)
        !v_reg[0] |-> star.ready)
        else $error("input stalled while first stage is empty");

endmodule

// File: sim/star_point_projector_test.sv
`timescale 1ns / 1ps

module star_point_projector_test;

    localparam int    CB              = spp_pkg::COORD_BITS_DEF;
    localparam longint COORD_MAX      = (longint'(1) <<< (CB - 1)) - 1;
    localparam longint COORD_MIN      = -(longint'(1) <<< (CB - 1));
    localparam int    DRAIN_CYCLES    = 30;
    localparam int    WATCHDOG_CYCLES = 3000;
    localparam int    HOLD_CYCLES     = 400;
    localparam logic [spp_pkg::CFG_ADDR_BITS-1:0] REG_FIRST_UNUSED = 3'd5;

    typedef struct {
        logic                 mode;
        logic signed [CB-1:0] x;
        logic signed [CB-1:0] y;
        logic signed [CB-1:0] z;
    } star_item_t;

    typedef struct packed {
        logic [spp_pkg::WORD_BITS-1:0] word_high;
        logic [spp_pkg::WORD_BITS-1:0] word_low;
        logic                          last_of_run;
    } cmd_beat_t;

    logic clk = 1'b0;
    logic rst_n;

    spp_in_if #(.COORD_BITS(CB)) star_ch ();
    spp_out_if                   cmd_ch ();
    spp_cfg_if                   cfg_ch ();

    star_point_projector #(.COORD_BITS(CB)) u_top
    (
        .clk   (clk),
        .rst_n (rst_n),
        .star  (star_ch),
        .cmd   (cmd_ch),
        .cfg   (cfg_ch)
    );

    // Shadow copy of the register file
    logic [spp_pkg::SCALE_BITS-1:0]  proj_scale = '0;
    logic [spp_pkg::FADE_BITS-1:0]   fade_scale = '0;
    logic [spp_pkg::SCREEN_BITS-1:0] scr_w      = spp_pkg::SCREEN_W_RST;
    logic [spp_pkg::SCREEN_BITS-1:0] scr_h      = spp_pkg::SCREEN_H_RST;
    logic [spp_pkg::WORD_BITS-1:0]   setup_addr = '0;

    cmd_beat_t                         cmd_expect_q[$];
    logic [spp_pkg::CFG_ADDR_BITS-1:0] cfg_addr_q[$];
    logic [spp_pkg::WORD_BITS-1:0]     cfg_data_q[$];

    int  n_errors  = 0;
    int  n_items   = 0;
    int  n_frames  = 0;
    int  n_drawn   = 0;
    int  n_culled  = 0;
    int  n_beats   = 0;
    int  n_cfg     = 0;
    int  hold_req  = 0;
    int  hold_seen = 0;
    int  rx_hold   = 0;
    int  rx_gap    = 0;
    int  idle_run  = 0;
    bit  rx_steady = 1'b0;
    bit  tx_steady = 1'b0;

    always #5 clk = ~clk;

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Work out the command beats one accepted item gives
    function automatic void project_star(input star_item_t it);
        longint x, y, z, den, px, py, sx, sy, fall, shade;
        logic [7:0]                    s;
        logic [spp_pkg::WORD_BITS-1:0] ux, uy;
        n_items++;
        if (!it.mode)
        begin
            cmd_expect_q.push_back('{spp_pkg::CMD_SETUP, setup_addr, 1'b1});
            n_frames++;
            return;
        end
        x = it.x;
        y = it.y;
        z = it.z;
        if (z < spp_pkg::DEPTH_NEAR || z >= spp_pkg::DEPTH_FAR)
        begin
            n_culled++;
            return;
        end
        den = z <<< spp_pkg::PROD_SHIFT;
        px  = (x * longint'(proj_scale)) / den;
        py  = (y * longint'(proj_scale)) / den;
        sx  = px + longint'(scr_w >> 1);
        sy  = longint'(scr_h >> 1) - py;
        if (sx < 0 || sy < 0 || sx >= longint'(scr_w) || sy >= longint'(scr_h))
        begin
            n_culled++;
            return;
        end
        fall  = ((z - spp_pkg::DEPTH_NEAR) * longint'(fade_scale)) >>> spp_pkg::FADE_SHIFT;
        shade = spp_pkg::SHADE_MAX - fall;
        if (shade < 0)
            shade = 0;
        s  = shade[7:0];
        ux = sx[spp_pkg::WORD_BITS-1:0];
        uy = sy[spp_pkg::WORD_BITS-1:0];
        cmd_expect_q.push_back('{spp_pkg::CMD_COLOR, {s, s, s, spp_pkg::ALPHA_OPAQUE}, 1'b0});
        cmd_expect_q.push_back('{spp_pkg::CMD_RECT
                                 | ((ux + 1) << spp_pkg::RECT_X_POS)
                                 | ((uy + 1) << spp_pkg::RECT_Y_POS),
                                 (ux << spp_pkg::RECT_X_POS) | (uy << spp_pkg::RECT_Y_POS),
                                 1'b1});
        n_drawn++;
    endfunction

    function automatic star_item_t star_item(input logic mode, input longint x, input longint y,
                                             input longint z);
        star_item_t it;
        it.mode = mode;
        it.x    = x[CB-1:0];
        it.y    = y[CB-1:0];
        it.z    = z[CB-1:0];
        return it;
    endfunction

    // Coordinate bound that lands a little past the screen edge at this depth
    function automatic longint reach(input logic [spp_pkg::SCREEN_BITS-1:0] size,
                                     input longint z);
        longint lim;
        lim = (longint'(size) * z * 160) / longint'(proj_scale == 0 ? 1 : proj_scale);
        return (lim > COORD_MAX) ? COORD_MAX : lim;
    endfunction

    function automatic longint rand_span(input longint lim);
        return longint'($urandom_range(0, 32'(2 * lim))) - lim;
    endfunction

    // Star aimed at the screen, with some depths on either side of the planes
    function automatic star_item_t aimed_star();
        longint z;
        int     r;
        r = $urandom_range(0, 99);
        if (r < 5)
            z = spp_pkg::DEPTH_NEAR - 1 + $urandom_range(0, 2);
        else if (r < 10)
            z = spp_pkg::DEPTH_FAR - 2 + $urandom_range(0, 2);
        else
            z = $urandom_range(spp_pkg::DEPTH_NEAR, spp_pkg::DEPTH_FAR - 1);
        return star_item(1'b1, rand_span(reach(scr_w, z)), rand_span(reach(scr_h, z)), z);
    endfunction

    function automatic star_item_t random_item();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return star_item(1'b0, $urandom, $urandom, $urandom);
        if (r < 20)
            return star_item($urandom_range(0, 1), $urandom, $urandom, $urandom);
        return aimed_star();
    endfunction

    // Offer one item and hold it until the block takes the beat
    task automatic send_star(input star_item_t it);
        int gap;
        star_ch.valid  <= 1'b1;
        star_ch.mode   <= it.mode;
        star_ch.star_x <= it.x;
        star_ch.star_y <= it.y;
        star_ch.star_z <= it.z;
        do
            @(posedge clk);
        while (!star_ch.ready);
        project_star(it);
        gap = tx_steady ? 0 : pick_gap();
        if (gap > 0)
        begin
            star_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic run_phase(input int count);
        repeat (count) send_star(random_item());
    endtask

    task automatic wait_results();
        star_ch.valid <= 1'b0;
        while (cmd_expect_q.size() != 0)
            @(posedge clk);
    endtask

    // Let culled items still in flight clear before touching registers
    task automatic wait_idle();
        wait_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Write the queued registers back to back
    task automatic write_regs();
        logic [spp_pkg::CFG_ADDR_BITS-1:0] idx;
        logic [spp_pkg::WORD_BITS-1:0]     val;
        while (cfg_addr_q.size() != 0)
        begin
            idx = cfg_addr_q.pop_front();
            val = cfg_data_q.pop_front();
            cfg_ch.valid <= 1'b1;
            cfg_ch.addr  <= idx;
            cfg_ch.data  <= val;
            do
                @(posedge clk);
            while (!cfg_ch.ready);
            case (idx)
                spp_pkg::REG_PROJ_SCALE: proj_scale = val[spp_pkg::SCALE_BITS-1:0];
                spp_pkg::REG_FADE_SCALE: fade_scale = val[spp_pkg::FADE_BITS-1:0];
                spp_pkg::REG_SCREEN_W:   scr_w      = val[spp_pkg::SCREEN_BITS-1:0];
                spp_pkg::REG_SCREEN_H:   scr_h      = val[spp_pkg::SCREEN_BITS-1:0];
                spp_pkg::REG_SETUP_ADDR: setup_addr = val;
                default:                 ;
            endcase
            n_cfg++;
        end
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic set_config(input logic [spp_pkg::WORD_BITS-1:0] scale,
                              input logic [spp_pkg::WORD_BITS-1:0] fade,
                              input logic [spp_pkg::WORD_BITS-1:0] width,
                              input logic [spp_pkg::WORD_BITS-1:0] height,
                              input logic [spp_pkg::WORD_BITS-1:0] addr);
        wait_idle();
        cfg_addr_q = '{spp_pkg::REG_PROJ_SCALE, spp_pkg::REG_FADE_SCALE, spp_pkg::REG_SCREEN_W,
                       spp_pkg::REG_SCREEN_H, spp_pkg::REG_SETUP_ADDR};
        cfg_data_q = '{scale, fade, width, height, addr};
        write_regs();
    endtask

    // Reset values: zero scale puts every star mid-screen at full brightness
    task automatic test_reset_values();
        send_star(star_item(1'b0, 0, 0, 0));
        send_star(star_item(1'b1, 1000, -1000, 4096));
        send_star(star_item(1'b1, COORD_MIN, COORD_MAX, spp_pkg::DEPTH_FAR - 1));
    endtask

    // Depth planes, truncation, screen edges and shade clamp at 256.0 scale
    task automatic test_directed_cases();
        set_config(32'h0001_0000, 32'h0001_0000, 320, 240, 32'hFFFF_FFFF);
        send_star(star_item(1'b0, COORD_MAX, COORD_MAX, COORD_MAX));
        send_star(star_item(1'b0, COORD_MIN, COORD_MIN, COORD_MIN));
        send_star(star_item(1'b1, 0, 0, spp_pkg::DEPTH_NEAR - 1));
        send_star(star_item(1'b1, 0, 0, spp_pkg::DEPTH_NEAR));
        send_star(star_item(1'b1, 0, 0, spp_pkg::DEPTH_FAR - 1));
        send_star(star_item(1'b1, 0, 0, spp_pkg::DEPTH_FAR));
        send_star(star_item(1'b1, 0, 0, 0));
        send_star(star_item(1'b1, 0, 0, COORD_MIN));
        send_star(star_item(1'b1, COORD_MAX, COORD_MIN, spp_pkg::DEPTH_NEAR));
        send_star(star_item(1'b1, -99, 99, 25600));
        send_star(star_item(1'b1, -16000, 0, 25600));
        send_star(star_item(1'b1, -16100, 0, 25600));
        send_star(star_item(1'b1, 15900, 0, 25600));
        send_star(star_item(1'b1, 16000, 0, 25600));
        send_star(star_item(1'b1, 0, 12000, 25600));
        send_star(star_item(1'b1, 0, 12100, 25600));
        send_star(star_item(1'b1, 0, -11900, 25600));
        send_star(star_item(1'b1, 0, -12000, 25600));
    endtask

    // Writes beyond the register list must leave every register alone
    task automatic test_unused_indexes();
        wait_idle();
        for (int i = REG_FIRST_UNUSED; i < 2 ** spp_pkg::CFG_ADDR_BITS; i++)
        begin
            cfg_addr_q.push_back(spp_pkg::CFG_ADDR_BITS'(i));
            cfg_data_q.push_back(32'hFFFF_FFFF);
        end
        write_regs();
        send_star(star_item(1'b0, 0, 0, 0));
        send_star(star_item(1'b1, 5000, 3000, 40000));
    endtask

    // Largest and smallest screens, and zero size through the width mask
    task automatic test_screen_extremes();
        set_config(32'h00FF_FFFF, 32'h00FF_FFFF, 1023, 1023, 32'h0000_0000);
        run_phase(40);
        set_config(32'h0000_0000, 32'h0000_0000, 1, 1, $urandom);
        run_phase(30);
        set_config(32'h0001_0000, 32'h0000_8000, 32'hFFFF_FC00, 1023, $urandom);
        run_phase(20);
        set_config(32'h0001_0000, 32'h0000_8000, 320, 32'h0000_0400, $urandom);
        run_phase(20);
    endtask

    task automatic test_random_settings();
        set_config(32'h0001_0000, 32'h0001_0000, 320, 240, $urandom);
        run_phase(150);
        set_config($urandom_range(1 << 12, 1 << 20), $urandom_range(0, 32'hFF_FFFF),
                   $urandom_range(1, 1023), $urandom_range(1, 1023), $urandom);
        // stretch with no idling on either side
        rx_steady = 1'b1;
        tx_steady = 1'b1;
        run_phase(60);
        rx_steady = 1'b0;
        tx_steady = 1'b0;
        run_phase(60);
        set_config($urandom_range(1 << 12, 1 << 20), $urandom_range(0, 32'hFF_FFFF),
                   $urandom_range(1, 1023), $urandom_range(1, 1023), $urandom);
        run_phase(150);
    endtask

    // Receiver holds off while items keep coming, so the pipeline fills
    task automatic test_backpressure();
        hold_req++;
        tx_steady = 1'b1;
        repeat (60) send_star(aimed_star());
        tx_steady = 1'b0;
    endtask

    // Sender pauses mid-stream until every beat has come back
    task automatic test_drain_pause();
        run_phase(20);
        wait_results();
        run_phase(20);
    endtask

    // Receiver: random stalls, a long hold-off on request
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            cmd_ch.ready <= 1'b0;
        end
        else
        begin
            if (hold_req != hold_seen)
            begin
                hold_seen = hold_req;
                rx_hold   = HOLD_CYCLES;
            end
            if (rx_hold > 0)
            begin
                cmd_ch.ready <= 1'b0;
                rx_hold--;
            end
            else if (rx_gap > 0)
            begin
                cmd_ch.ready <= 1'b0;
                rx_gap--;
            end
            else
            begin
                cmd_ch.ready <= 1'b1;
                if (!rx_steady)
                    rx_gap = pick_gap();
            end
        end
    end

    // Check each command beat against the oldest expectation
    always @(posedge clk)
    begin : check_cmd
        cmd_beat_t want;
        if (rst_n && cmd_ch.valid && cmd_ch.ready)
        begin
            n_beats++;
            if (cmd_expect_q.size() == 0)
            begin
                $error("command beat with none expected: word_high %h word_low %h",
                       cmd_ch.word_high, cmd_ch.word_low);
                n_errors++;
            end
            else
            begin
                want = cmd_expect_q.pop_front();
                if (cmd_ch.word_high !== want.word_high)
                begin
                    $error("word_high: expected %h, got %h", want.word_high, cmd_ch.word_high);
                    n_errors++;
                end
                if (cmd_ch.word_low !== want.word_low)
                begin
                    $error("word_low: expected %h, got %h", want.word_low, cmd_ch.word_low);
                    n_errors++;
                end
                if (cmd_ch.last_of_run !== want.last_of_run)
                begin
                    $error("last_of_run: expected %b, got %b",
                           want.last_of_run, cmd_ch.last_of_run);
                    n_errors++;
                end
            end
        end
    end

    // Drop the run if no beat moves on any channel for too long
    always @(posedge clk)
    begin
        if (!rst_n || (star_ch.valid && star_ch.ready) || (cmd_ch.valid && cmd_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready))
            idle_run = 0;
        else
            idle_run++;
        if (idle_run >= WATCHDOG_CYCLES)
        begin
            $display("star_point_projector_test: done, errors");
            $finish;
        end
    end

    initial
    begin
        rst_n          = 1'b0;
        star_ch.valid  = 1'b0;
        star_ch.mode   = 1'b0;
        star_ch.star_x = '0;
        star_ch.star_y = '0;
        star_ch.star_z = '0;
        cfg_ch.valid   = 1'b0;
        cfg_ch.addr    = '0;
        cfg_ch.data    = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_values();
        test_directed_cases();
        test_unused_indexes();
        test_screen_extremes();
        test_random_settings();
        test_backpressure();
        test_drain_pause();
        wait_idle();

        $display("covered %0d items: %0d frame starts, %0d stars drawn, %0d dropped or culled",
                 n_items, n_frames, n_drawn, n_culled);
        $display("checked %0d command beats over %0d register writes, with hold-off and drain",
                 n_beats, n_cfg);
        if (n_errors == 0)
            $display("star_point_projector_test: done, clean");
        else
            $display("star_point_projector_test: done, errors");
        $finish;
    end

endmodule
